@@ rtl/b2da_pkg.sv @@
`default_nettype none

package b2da_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // Decimal digits needed for a width-bit unsigned value: floor(width*log10(2)) + 1
    function automatic int bcd_digits(input int width);
        return (width * 30103) / 100000 + 1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/b2da_dabble.sv @@
`default_nettype none

module b2da_dabble #(
    parameter int DATA_WIDTH = b2da_pkg::DATA_WIDTH_DEF,
    parameter int NDIG       = b2da_pkg::bcd_digits(DATA_WIDTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DATA_WIDTH-1:0] i_bin,
    output logic                       o_done,
    output logic [NDIG*4-1:0]          o_bcd
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_bin;
    logic [NDIG*4-1:0]     r_bcd;
    logic [NDIG*4-1:0]     n_adj;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    // add 3 to every digit of 5 or more before the next shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CNT_W'(DATA_WIDTH);
            end else if (r_busy) begin
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == CNT_W'(1));
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bcd <= {n_adj[NDIG*4-2:0], r_bin[DATA_WIDTH-1]};
            r_bin <= {r_bin[DATA_WIDTH-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

`default_nettype wire

@@ rtl/binary_to_decimal_ascii_unit.sv @@
`default_nettype none

// Prints one binary number per input transaction as ASCII decimal text, most
// significant digit first, one character per output transaction, with tlast on
// the final character. tuser set reads tdata as two's complement: a negative
// value is preceded by '-'. Leading zeros are dropped; zero prints as "0".
// A number runs through the bit-serial double-dabble loop, which keeps NDIG
// digits, the decimal digit count of a full-width value; leading zeros are
// then skipped one at a time, and each character is sent once the output
// register is free. A new number is taken once the last character sits in
// the output register.
module binary_to_decimal_ascii_unit #(
    parameter int DATA_WIDTH = b2da_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // value
    input  wire logic                               s_axis_tuser,  // is_signed
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [7:0]                              m_axis_tdata,  // ascii_char
    output logic                                    m_axis_tlast   // last
);

    localparam int NDIG   = b2da_pkg::bcd_digits(DATA_WIDTH);
    localparam int LEFT_W = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic                  r_neg;
    logic [NDIG*4-1:0]     r_dig;
    logic [LEFT_W-1:0]     r_left;
    logic                  r_m_tvalid;
    logic [7:0]            r_m_tdata;
    logic                  r_m_tlast;

    logic                  w_accept;
    logic                  w_neg_in;
    logic [DATA_WIDTH-1:0] w_value;
    logic [DATA_WIDTH-1:0] w_mag;
    logic                  w_done;
    logic [NDIG*4-1:0]     w_bcd;
    logic                  w_slot;
    logic                  w_emit;
    logic [3:0]            w_top;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_value  = s_axis_tdata[DATA_WIDTH-1:0];
    assign w_neg_in = s_axis_tuser && w_value[DATA_WIDTH-1];
    assign w_mag    = w_neg_in ? (~w_value + DATA_WIDTH'(1)) : w_value;
    assign w_slot   = !r_m_tvalid || m_axis_tready;
    assign w_emit   = (r_state == S_EMIT) && w_slot;
    assign w_top    = r_dig[NDIG*4-1 -: 4];

    b2da_dabble #(
        .DATA_WIDTH (DATA_WIDTH),
        .NDIG       (NDIG)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_bin   (w_mag),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_neg      <= 1'b0;
            r_left     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (m_axis_tready && !w_emit) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_neg   <= w_neg_in;
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (w_done) begin
                        r_left  <= LEFT_W'(NDIG);
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    // drop one leading zero per cycle, keep at least one digit
                    if (w_top == 4'd0 && r_left != LEFT_W'(1)) begin
                        r_left <= r_left - LEFT_W'(1);
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_m_tvalid <= 1'b1;
                        if (r_neg) begin
                            r_m_tdata <= b2da_pkg::ASCII_MINUS;
                            r_m_tlast <= 1'b0;
                            r_neg     <= 1'b0;
                        end else begin
                            r_m_tdata <= b2da_pkg::ASCII_ZERO + {4'b0000, w_top};
                            r_m_tlast <= (r_left == LEFT_W'(1));
                            r_left    <= r_left - LEFT_W'(1);
                            if (r_left == LEFT_W'(1)) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // digit shift register: load from converter, advance one digit per skip or digit sent
    always_ff @(posedge i_clk) begin
        if (r_state == S_CONV && w_done) begin
            r_dig <= w_bcd;
        end else if ((r_state == S_SKIP && w_top == 4'd0 && r_left != LEFT_W'(1)) ||
                     (r_state == S_EMIT && w_slot && !r_neg)) begin
            r_dig <= {r_dig[NDIG*4-5:0], 4'b0000};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tlast  = r_m_tlast;

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input taken again right after a transaction");

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_CONV)
        else $error("conversion finished outside the conversion state");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata == b2da_pkg::ASCII_MINUS) |-> !m_axis_tlast)
        else $error("minus sign marked as last character");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP || r_state == S_EMIT) |-> r_left != '0)
        else $error("digit count ran out before the last character");

endmodule

`default_nettype wire
